// ===== hdl/bpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_pkg - shared types and constants of the button press classifier
// Event codes, configuration record, phase encoding and reset values.
// ----------------------------------------------------------------------------
package bpc_pkg;

	localparam int unsigned EVENT_W      = 3;
	localparam int unsigned DEBOUNCE_W   = 8;
	localparam int unsigned LONG_W       = 16;

	// button index of the reset button
	localparam logic [EVENT_W-1:0] RESET_BUTTON = 3'd2;

	// event codes besides the plain per-button press codes
	localparam logic [EVENT_W-1:0] EV_RESET_SHORT = 3'd2;
	localparam logic [EVENT_W-1:0] EV_RESET_LONG  = 3'd4;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd50;
	localparam logic [LONG_W-1:0]     LONG_RESET     = 16'd3000;

	typedef struct packed {
		logic [DEBOUNCE_W-1:0] debounce_ticks;
		logic [LONG_W-1:0]     long_press_ticks;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic [EVENT_W-1:0] code;
	} result_t;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'b001,
		PH_DEBOUNCE = 3'b010,
		PH_HELD     = 3'b100
	} phase_t;

endpackage

`default_nettype wire

// ===== hdl/bpc_apb_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_apb_regs - configuration registers
// APB-style slave holding the debounce and long-press thresholds.
// ----------------------------------------------------------------------------
module bpc_apb_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic      [31:0]   prdata,
	output logic               pready,
	output bpc_pkg::cfg_t      cfg
);

	// word select; byte offset bits are ignored
	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_LONG     = 1'b1;

	logic [bpc_pkg::DEBOUNCE_W-1:0] debounce_q;
	logic [bpc_pkg::LONG_W-1:0]     long_q;
	logic                           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= bpc_pkg::DEBOUNCE_RESET;
			long_q     <= bpc_pkg::LONG_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_DEBOUNCE: debounce_q <= pwdata[bpc_pkg::DEBOUNCE_W-1:0];
				REG_LONG:     long_q     <= pwdata[bpc_pkg::LONG_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DEBOUNCE: prdata = {{(32-bpc_pkg::DEBOUNCE_W){1'b0}}, debounce_q};
			REG_LONG:     prdata = {{(32-bpc_pkg::LONG_W){1'b0}}, long_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg.debounce_ticks   = debounce_q;
	assign cfg.long_press_ticks = long_q;

endmodule

`default_nettype wire

// ===== hdl/bpc_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_classifier - edge capture, debounce and press classification
// One tick of button levels per step; state advances only when step is high.
// ----------------------------------------------------------------------------
module bpc_classifier #(
	parameter int unsigned NUM_BUTTONS = 4,
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   step,
	input  wire logic [NUM_BUTTONS-1:0] levels,
	input  wire bpc_pkg::cfg_t          cfg,
	output bpc_pkg::result_t            res
);

	localparam int unsigned IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int unsigned CMP_W = (COUNT_WIDTH > bpc_pkg::LONG_W) ?
		COUNT_WIDTH : bpc_pkg::LONG_W;

	logic [NUM_BUTTONS-1:0] prev_q, pend_q, pend_d, pend_m, falling;
	bpc_pkg::phase_t        phase_q, phase_d;
	logic [IDX_W-1:0]       act_q, act_d, pick;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;
	logic                   long_sent_q, long_sent_d;
	logic                   pressed, is_reset;
	logic [CMP_W-1:0]       cnt_ext, inc_ext, long_ext, deb_ext;

	assign falling  = prev_q & ~levels;
	assign pend_m   = pend_q | falling;
	assign pressed  = ~levels[act_q];
	assign is_reset = (bpc_pkg::EVENT_W'(act_q) == bpc_pkg::RESET_BUTTON);
	assign cnt_inc  = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_WIDTH'(1);
	assign cnt_ext  = CMP_W'(cnt_q);
	assign inc_ext  = CMP_W'(cnt_inc);
	assign long_ext = CMP_W'(cfg.long_press_ticks);
	assign deb_ext  = CMP_W'(cfg.debounce_ticks);

	// lowest pending button wins
	always_comb begin
		pick = '0;
		for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
			if (pend_m[i]) pick = IDX_W'(i);
		end
	end

	always_comb begin
		phase_d     = phase_q;
		pend_d      = pend_m;
		act_d       = act_q;
		cnt_d       = cnt_q;
		long_sent_d = long_sent_q;
		res.valid   = 1'b0;
		res.code    = bpc_pkg::EVENT_W'(act_q);
		unique case (phase_q)
			bpc_pkg::PH_DEBOUNCE: begin
				if (cnt_ext < deb_ext) begin
					cnt_d = cnt_q + COUNT_WIDTH'(1);
				end else if (pressed) begin
					phase_d     = bpc_pkg::PH_HELD;
					cnt_d       = '0;
					long_sent_d = 1'b0;
				end else begin
					phase_d = bpc_pkg::PH_IDLE;
				end
			end
			bpc_pkg::PH_HELD: begin
				if (pressed) begin
					cnt_d = cnt_inc;
					if (is_reset && !long_sent_q && inc_ext >= long_ext) begin
						long_sent_d = 1'b1;
						res.valid   = 1'b1;
						res.code    = bpc_pkg::EV_RESET_LONG;
					end
				end else begin
					if (is_reset) begin
						res.valid = !long_sent_q && (cnt_ext < long_ext);
						res.code  = bpc_pkg::EV_RESET_SHORT;
					end else begin
						res.valid = 1'b1;
					end
					phase_d = bpc_pkg::PH_IDLE;
				end
			end
			default: begin
				// idle, and any stray code behaves as idle
				phase_d = bpc_pkg::PH_IDLE;
				if (pend_m != '0) begin
					pend_d  = pend_m & ~(NUM_BUTTONS'(1) << pick);
					act_d   = pick;
					cnt_d   = '0;
					phase_d = bpc_pkg::PH_DEBOUNCE;
				end
			end
		endcase
		if (!step) res.valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '1;
			pend_q      <= '0;
			phase_q     <= bpc_pkg::PH_IDLE;
			act_q       <= '0;
			cnt_q       <= '0;
			long_sent_q <= 1'b0;
		end else if (step) begin
			prev_q      <= levels;
			pend_q      <= pend_d;
			phase_q     <= phase_d;
			act_q       <= act_d;
			cnt_q       <= cnt_d;
			long_sent_q <= long_sent_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/button_press_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A staged tick yields its event in the output register when the classifier steps on it.
// Throughput: one tick per cycle; the single classifier step sits between the input
// stage register and the output register; only a full, unread output register stalls it.
// Reset (arst_n low, asynchronous): stages empty, buttons seen as released, no pending
// presses, thresholds back to 50 debounce ticks and 3000 long-press ticks.
// ----------------------------------------------------------------------------
// button_press_classifier - debounced short/long button press events
// Stream of active-low button samples in, stream of press event codes out,
// APB-style port for the two thresholds.
// ----------------------------------------------------------------------------
module button_press_classifier #(
	parameter int unsigned NUM_BUTTONS = 4,
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// input sample stream
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [((NUM_BUTTONS+7)/8)*8-1:0] s_axis_tdata, // [NUM_BUTTONS-1:0] button_levels
	// event stream
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [7:0]        m_axis_tdata,  // [2:0] event_code
	// configuration
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready
);

	bpc_pkg::cfg_t          cfg;
	bpc_pkg::result_t       res;

	// input stage
	logic                   valid_s1;
	logic [NUM_BUTTONS-1:0] levels_s1;

	// output register
	logic                   out_valid_q;
	logic [bpc_pkg::EVENT_W-1:0] out_code_q;

	// the classifier steps when the staged tick can land somewhere
	logic                   advance;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			levels_s1 <= s_axis_tdata[NUM_BUTTONS-1:0];
		end
	end

	bpc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bpc_classifier #(
		.NUM_BUTTONS (NUM_BUTTONS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_classifier (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.levels (levels_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// a tick that causes no event still retires; the register then just drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_code_q <= res.code;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(8-bpc_pkg::EVENT_W){1'b0}}, out_code_q};

	// staged tick holds while the output side is blocked
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(levels_s1))
		else $error("staged tick lost or changed while stalled");

	// no event appears without a classifier step
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!advance && !out_valid_q |=> !out_valid_q)
		else $error("event raised without a processed tick");

	// a taken event is not repeated when the next tick has no event
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && m_axis_tready && !(advance && res.valid) |=> !out_valid_q)
		else $error("event transaction repeated");

endmodule

`default_nettype wire
